// File: design/idll_pkg.sv
package idll_pkg;

    // Field widths fixed by the interface
    localparam int ID_W       = 11;
    localparam int KIND_W     = 2;

    // Default node count and widest link memory address supported
    localparam int NODES_DEF  = 1024;
    localparam int ADDR_MAX_W = 16;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        K_UNLINK = 2'd0,
        K_BEFORE = 2'd1,
        K_AFTER  = 2'd2,
        K_QUERY  = 2'd3
    } t_kind;

    // One request to a link memory: one write and one read per cycle
    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [ID_W-1:0]       wdata;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: design/idll_ram.sv
module idll_ram
    import idll_pkg::*;
#(
    parameter int DEPTH = NODES_DEF
) (
    input  logic            i_clk,
    input  t_ram_req        i_req,
    output logic [ID_W-1:0] o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/idll_ctrl.sv
module idll_ctrl
    import idll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ID_W-1:0]   i_node,
    input  logic [ID_W-1:0]   i_other,
    input  logic [ID_W-1:0]   i_prev_rd,
    input  logic [ID_W-1:0]   i_next_rd,
    output logic              busy,
    output logic              o_valid,
    output logic [ID_W-1:0]   o_prev_node,
    output logic [ID_W-1:0]   o_next_node,
    output t_ram_req          o_prev_req,
    output t_ram_req          o_next_req
);

    localparam int AW = $clog2(NODES);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    t_kind           r_kind;
    logic [ID_W-1:0] r_x, r_y;
    logic            r_ok;

    logic  accept, x_ok, y_ok, go;
    t_kind in_kind;
    logic [ID_W-1:0] p, n;

    // Node id 1..NODES maps to memory entry id-1
    function automatic logic [ADDR_MAX_W-1:0] to_addr(input logic [ID_W-1:0] id);
        return ADDR_MAX_W'(id) - ADDR_MAX_W'(1);
    endfunction

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) <= 32'(NODES));
    endfunction

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && (r_state == S_IDLE);
    assign in_kind = t_kind'(i_kind);
    assign x_ok    = id_ok(i_node);
    assign y_ok    = id_ok(i_other);
    assign go      = (in_kind == K_QUERY) ||
                     (x_ok && ((in_kind == K_UNLINK) || (y_ok && (i_node != i_other))));

    // Neighbors of the current node, straight from the memory read registers
    assign p = i_prev_rd;
    assign n = i_next_rd;

    // Query result: strobed in the cycle after the transfer
    assign o_valid     = (r_state == S_READ) && (r_kind == K_QUERY);
    assign o_prev_node = r_ok ? p : '0;
    assign o_next_node = r_ok ? n : '0;

    // Sequencer and memory requests
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        o_prev_req = '0;
        o_next_req = '0;

        // read both links of the node at the transfer
        o_prev_req.re    = accept;
        o_prev_req.raddr = to_addr(i_node);
        o_next_req.re    = accept;
        o_next_req.raddr = to_addr(i_node);

        case (r_state)
            S_CLEAR: begin
                o_prev_req.we    = 1'b1;
                o_prev_req.waddr = ADDR_MAX_W'(r_clr);
                o_next_req.we    = 1'b1;
                o_next_req.waddr = ADDR_MAX_W'(r_clr);
                n_clr            = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && go) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // neighbor updates first, in the order each memory sees them
                n_state = S_FINISH;
                case (r_kind)
                    K_UNLINK: begin
                        o_next_req.we    = (p != '0);
                        o_next_req.waddr = to_addr(p);
                        o_next_req.wdata = n;
                        o_prev_req.we    = (n != '0);
                        o_prev_req.waddr = to_addr(n);
                        o_prev_req.wdata = p;
                    end
                    K_BEFORE: begin
                        o_next_req.we    = (p != '0);
                        o_next_req.waddr = to_addr(p);
                        o_next_req.wdata = r_y;
                        o_prev_req.we    = 1'b1;
                        o_prev_req.waddr = to_addr(r_y);
                        o_prev_req.wdata = p;
                    end
                    K_AFTER: begin
                        o_prev_req.we    = (n != '0);
                        o_prev_req.waddr = to_addr(n);
                        o_prev_req.wdata = r_y;
                        o_next_req.we    = 1'b1;
                        o_next_req.waddr = to_addr(r_y);
                        o_next_req.wdata = n;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FINISH: begin
                // second write to each memory
                n_state = S_IDLE;
                case (r_kind)
                    K_UNLINK: begin
                        o_prev_req.we    = 1'b1;
                        o_prev_req.waddr = to_addr(r_x);
                        o_prev_req.wdata = '0;
                        o_next_req.we    = 1'b1;
                        o_next_req.waddr = to_addr(r_x);
                        o_next_req.wdata = '0;
                    end
                    K_BEFORE: begin
                        o_next_req.we    = 1'b1;
                        o_next_req.waddr = to_addr(r_y);
                        o_next_req.wdata = r_x;
                        o_prev_req.we    = 1'b1;
                        o_prev_req.waddr = to_addr(r_x);
                        o_prev_req.wdata = r_y;
                    end
                    K_AFTER: begin
                        o_prev_req.we    = 1'b1;
                        o_prev_req.waddr = to_addr(r_y);
                        o_prev_req.wdata = r_x;
                        o_next_req.we    = 1'b1;
                        o_next_req.waddr = to_addr(r_x);
                        o_next_req.wdata = r_y;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Operands of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= in_kind;
            r_x    <= i_node;
            r_y    <= i_other;
            r_ok   <= x_ok;
        end
    end

endmodule

// File: design/indexed_doubly_linked_list.sv
// Indexed doubly linked list. Each node 1..NODES has a predecessor and a
// successor link (0 = none) held in two single-port-write, registered-read
// memories. After reset busy stays high for a clearing pass over all NODES
// entries. An item transfers when start is high and busy is low. A query's
// result appears on o_prev_node/o_next_node with o_valid high for exactly one
// cycle, the cycle after the transfer, and cannot be held off. Unlink and
// insert run as a transfer with link read, then two writes to each link
// memory through its one write port; an unlink or insert with an
// out-of-range id, or an insert of a node next to itself, does nothing and
// leaves busy low.
module indexed_doubly_linked_list
    import idll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ID_W-1:0]   i_node,
    input  logic [ID_W-1:0]   i_other,
    output logic              busy,
    output logic              o_valid,
    output logic [ID_W-1:0]   o_prev_node,
    output logic [ID_W-1:0]   o_next_node
);

    t_ram_req        prev_req, next_req;
    logic [ID_W-1:0] prev_rd, next_rd;

    // Sequencer
    idll_ctrl #(
        .NODES(NODES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_kind     (i_kind),
        .i_node     (i_node),
        .i_other    (i_other),
        .i_prev_rd  (prev_rd),
        .i_next_rd  (next_rd),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_prev_node(o_prev_node),
        .o_next_node(o_next_node),
        .o_prev_req (prev_req),
        .o_next_req (next_req)
    );

    // Predecessor links
    idll_ram #(
        .DEPTH(NODES)
    ) u_prev_ram (
        .i_clk    (i_clk),
        .i_req    (prev_req),
        .o_rd_data(prev_rd)
    );

    // Successor links
    idll_ram #(
        .DEPTH(NODES)
    ) u_next_ram (
        .i_clk    (i_clk),
        .i_req    (next_req),
        .o_rd_data(next_rd)
    );

    // A query transfer gives a result strobe in the next cycle
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == K_QUERY)) |=> o_valid)
        else $error("query without result strobe");

    // Result strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // No link memory is written while the block reports idle
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (prev_req.we || next_req.we) |-> busy)
        else $error("link write while idle");

    // Results only come out of an item in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy && !prev_req.we && !next_req.we))
        else $error("result strobe outside read cycle");

endmodule

// File: dv/idll_link_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the linked list block, keeps its
// own copy of both link tables and checks each query result in order.
module idll_link_checker
    import idll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ID_W-1:0]   i_node,
    input  logic [ID_W-1:0]   i_other,
    input  logic              i_valid,
    input  logic [ID_W-1:0]   i_prev_node,
    input  logic [ID_W-1:0]   i_next_node,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [ID_W-1:0] prev_id;
        logic [ID_W-1:0] next_id;
    } t_links;

    // Mirror of the link tables; entry 0 is never written
    logic [ID_W-1:0] prev_of [0:NODES];
    logic [ID_W-1:0] next_of [0:NODES];

    // Query answers still owed by the block, oldest first
    t_links expected_links_q[$];

    initial begin
        for (int i = 0; i <= NODES; i++) begin
            prev_of[i] = '0;
            next_of[i] = '0;
        end
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic bit id_ok(logic [ID_W-1:0] id);
        return (id >= 1) && (id <= NODES);
    endfunction

    // Apply one command to the mirrored tables; a query queues its answer
    task automatic apply_list_op(t_kind kind, logic [ID_W-1:0] x, logic [ID_W-1:0] y);
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] n;
        t_links          ans;
        case (kind)
            K_QUERY: begin
                ans = '0;
                if (id_ok(x)) begin
                    ans.prev_id = prev_of[x];
                    ans.next_id = next_of[x];
                end
                expected_links_q.push_back(ans);
            end
            K_UNLINK: begin
                if (id_ok(x)) begin
                    p = prev_of[x];
                    n = next_of[x];
                    if (p != 0) next_of[p] = n;
                    if (n != 0) prev_of[n] = p;
                    prev_of[x] = '0;
                    next_of[x] = '0;
                end
            end
            K_BEFORE: begin
                if (id_ok(x) && id_ok(y) && x != y) begin
                    p = prev_of[x];
                    if (p != 0) next_of[p] = y;
                    prev_of[y] = p;
                    next_of[y] = x;
                    prev_of[x] = y;
                end
            end
            K_AFTER: begin
                if (id_ok(x) && id_ok(y) && x != y) begin
                    n = next_of[x];
                    if (n != 0) prev_of[n] = y;
                    next_of[y] = n;
                    prev_of[y] = x;
                    next_of[x] = y;
                end
            end
        endcase
    endtask

    // Results are checked before the command of the same edge is applied:
    // a result always belongs to an earlier transfer
    always @(posedge i_clk) begin
        t_links want;
        if (i_rst_n) begin
            if (i_valid !== 1'b0) begin
                if (expected_links_q.size() == 0) begin
                    $error("result with no query outstanding: prev_node=%0d next_node=%0d",
                           i_prev_node, i_next_node);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_links_q.pop_front();
                    o_checked = o_checked + 1;
                    if (i_prev_node !== want.prev_id) begin
                        $error("prev_node: expected %0d, got %0d", want.prev_id, i_prev_node);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_next_node !== want.next_id) begin
                        $error("next_node: expected %0d, got %0d", want.next_id, i_next_node);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_list_op(t_kind'(i_kind), i_node, i_other);
            end
            o_pending = expected_links_q.size();
        end
    end

endmodule

// File: dv/indexed_doubly_linked_list_tb.sv
`timescale 1ns / 1ps

module indexed_doubly_linked_list_tb;
    import idll_pkg::*;

    localparam int NODES        = NODES_DEF;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 8;
    // clearing pass plus ~930 items at worst-case length with the longest gaps, many times over
    localparam int LIMIT_CYCLES = 400000;
    localparam int LOCAL_SPAN   = 24;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [KIND_W-1:0] i_kind  = '0;
    logic [ID_W-1:0]   i_node  = '0;
    logic [ID_W-1:0]   i_other = '0;
    logic              busy;
    logic              o_valid;
    logic [ID_W-1:0]   o_prev_node;
    logic [ID_W-1:0]   o_next_node;

    int fail_count;
    int pending_queries;
    int checked_queries;
    int cycle_count = 0;
    int kind_count [0:3];
    bit no_gap_stretch;

    // Rough view of which ids currently sit in some list
    bit in_list [0:(1 << ID_W) - 1];

    always #(CLK_HALF) i_clk = ~i_clk;

    indexed_doubly_linked_list #(
        .NODES (NODES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_kind      (i_kind),
        .i_node      (i_node),
        .i_other     (i_other),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_prev_node (o_prev_node),
        .o_next_node (o_next_node)
    );

    idll_link_checker #(
        .NODES (NODES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_node       (i_node),
        .i_other      (i_other),
        .i_valid      (o_valid),
        .i_prev_node  (o_prev_node),
        .i_next_node  (o_next_node),
        .o_fail_count (fail_count),
        .o_pending    (pending_queries),
        .o_checked    (checked_queries)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one command and hold it until the transfer; start stays high
    task automatic send_item(t_kind kind, logic [ID_W-1:0] node, logic [ID_W-1:0] other);
        start   <= 1'b1;
        i_kind  <= kind;
        i_node  <= node;
        i_other <= other;
        do @(posedge i_clk); while (busy !== 1'b0);
        kind_count[kind]++;
        if (kind == K_UNLINK && node >= 1 && node <= NODES) begin
            in_list[node] = 1'b0;
        end else if ((kind == K_BEFORE || kind == K_AFTER) && node != other &&
                     node >= 1 && node <= NODES && other >= 1 && other <= NODES) begin
            in_list[node]  = 1'b1;
            in_list[other] = 1'b1;
        end
    endtask

    // Drop start for some cycles, with junk on the fields
    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            start   <= 1'b0;
            i_kind  <= KIND_W'($urandom);
            i_node  <= ID_W'($urandom);
            i_other <= ID_W'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_stretch || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold off until every query answer is in and the block is idle
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_queries != 0 || busy !== 1'b0);
        @(posedge i_clk);
    endtask

    // Mostly well-formed list traffic on a small set of ids, some noise
    task automatic random_item();
        int              r;
        int              span;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        span = ($urandom_range(0, 9) == 0) ? NODES : LOCAL_SPAN;
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            send_item(t_kind'($urandom_range(0, 3)), ID_W'($urandom), ID_W'($urandom));
        end else if (r < 35) begin
            send_item(K_QUERY, ID_W'($urandom_range(1, span)), ID_W'($urandom));
        end else if (r < 60) begin
            a = ID_W'($urandom_range(1, span));
            for (int t = 0; t < 8 && !in_list[a]; t++) a = ID_W'($urandom_range(1, span));
            send_item(K_UNLINK, a, ID_W'($urandom));
        end else begin
            a = ID_W'($urandom_range(1, span));
            for (int t = 0; t < 4 && !in_list[a]; t++) a = ID_W'($urandom_range(1, span));
            b = ID_W'($urandom_range(1, span));
            for (int t = 0; t < 16 && (in_list[b] || b == a); t++) begin
                b = ID_W'($urandom_range(1, span));
            end
            send_item($urandom_range(0, 1) ? K_BEFORE : K_AFTER, a, b);
        end
    endtask

    initial begin
        for (int k = 0; k < 4; k++) kind_count[k] = 0;
        no_gap_stretch = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fresh node, out-of-range ids, a small list built and torn down
        send_item(K_QUERY, 11'd1, 11'd0);
        send_item(K_QUERY, 11'd0, 11'd2047);
        send_item(K_QUERY, 11'd1025, 11'd0);
        send_item(K_QUERY, 11'd2047, 11'd2047);
        send_item(K_AFTER, 11'd1, 11'd2);
        send_item(K_BEFORE, 11'd1, 11'd3);
        send_item(K_AFTER, 11'd2, 11'd1024);
        send_item(K_QUERY, 11'd1, 11'd0);
        send_item(K_QUERY, 11'd1024, 11'd0);
        send_item(K_QUERY, 11'd3, 11'd0);
        // insert next to itself and inserts with a bad id do nothing
        send_item(K_BEFORE, 11'd1, 11'd1);
        send_item(K_AFTER, 11'd0, 11'd5);
        send_item(K_AFTER, 11'd2047, 11'd5);
        send_item(K_BEFORE, 11'd1, 11'd0);
        send_item(K_AFTER, 11'd1, 11'd2047);
        send_item(K_UNLINK, 11'd0, 11'd0);
        send_item(K_UNLINK, 11'd2047, 11'd2047);
        send_item(K_UNLINK, 11'd1, 11'd0);
        send_item(K_QUERY, 11'd3, 11'd0);
        send_item(K_QUERY, 11'd1, 11'd0);
        send_item(K_UNLINK, 11'd1024, 11'd0);
        send_item(K_UNLINK, 11'd3, 11'd0);
        send_item(K_QUERY, 11'd2, 11'd0);
        send_item(K_BEFORE, 11'd2, 11'd1365);
        send_item(K_BEFORE, 11'd2, 11'd682);
        send_item(K_QUERY, 11'd682, 11'd0);
        send_item(K_QUERY, 11'd2, 11'd0);
        wait_drained();

        // Random traffic, in stretches that each randomly run with or without gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) no_gap_stretch = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) wait_drained();
            random_item();
            idle_gap(pick_gap());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transfers: %0d unlink, %0d insert-before, %0d insert-after, %0d query",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[K_UNLINK], kind_count[K_BEFORE], kind_count[K_AFTER],
                 kind_count[K_QUERY]);
        $display("%0d query answers compared; mostly local ids, some across all %0d nodes",
                 checked_queries, NODES);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
design/idll_pkg.sv
design/idll_ram.sv
design/idll_ctrl.sv
design/indexed_doubly_linked_list.sv
dv/idll_link_checker.sv
dv/indexed_doubly_linked_list_tb.sv
